### design/gdbd_pkg.sv
// Package for the Gregorian day-count block: beat types, sequencer states,
// calendar constants and month-length helpers.
// No dependencies.
package gdbd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned MOD_W   = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd4194303;
    localparam logic [YEAR_W-1:0]  CYCLE_YRS  = 14'd400;
    localparam logic [MOD_W-1:0]   CYCLE_LAST = 9'd399;
    localparam logic [MOD_W-1:0]   CENTURY    = 9'd100;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP   = 5'd29;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic               include_end;
    } t_dbd_in;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               invalid_date;
    } t_dbd_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_E,
        ST_RED_S,
        ST_CHECK,
        ST_STEP,
        ST_OUT
    } t_state;

    // Leap test on the year taken modulo 400.
    function automatic logic leap_of(input logic [MOD_W-1:0] r);
        leap_of = (r[1:0] == 2'd0) && (r != CENTURY) && (r != 9'(2 * CENTURY))
                  && (r != 9'(3 * CENTURY));
    endfunction

    // Month length; 0 for a month code outside the calendar.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
            MONTH_FEB: month_len = leap ? FEB_LEAP : 5'd28;
            default:   month_len = 5'd0;
        endcase
    endfunction

    function automatic logic date_ok(input logic [MONTH_W-1:0] m,
                                     input logic [DAY_W-1:0] d, input logic leap);
        logic [DAY_W-1:0] n;
        n = month_len(m, leap);
        date_ok = (n != 5'd0) && (d != 5'd0) && (d <= n);
    endfunction

endpackage

### design/gregorian_days_between_dates.sv
// Gregorian day count between two dates, walking the start date one day a beat.
// One item at a time; the input stalls while the sequencer is busy.
// Throughput is set by the day-step loop: one calendar day per cycle.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
// Depends on gdbd_pkg.
module gregorian_days_between_dates
    import gdbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dbd_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dbd_out o_out
);

    t_state             r_state, n_state;
    t_dbd_in            r_in, n_in;
    logic [YEAR_W-1:0]  r_rem, n_rem;
    logic               r_end_leap, n_end_leap;
    logic [MOD_W-1:0]   r_mod400, n_mod400;
    logic [YEAR_W-1:0]  r_y, n_y;
    logic [MONTH_W-1:0] r_m, n_m;
    logic [DAY_W-1:0]   r_d, n_d;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_bad, n_bad;
    logic               r_out_valid, n_out_valid;
    t_dbd_out           r_out, n_out;

    logic               before_end;
    logic               cur_leap;

    assign cur_leap   = leap_of(r_mod400);
    assign before_end = {r_y, r_m, r_d} < {r_in.end_year, r_in.end_month, r_in.end_day};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_in       <= n_in;
        r_rem      <= n_rem;
        r_end_leap <= n_end_leap;
        r_mod400   <= n_mod400;
        r_y        <= n_y;
        r_m        <= n_m;
        r_d        <= n_d;
        r_count    <= n_count;
        r_bad      <= n_bad;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_rem       = r_rem;
        n_end_leap  = r_end_leap;
        n_mod400    = r_mod400;
        n_y         = r_y;
        n_m         = r_m;
        n_d         = r_d;
        n_count     = r_count;
        n_bad       = r_bad;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_rem   = i_in.end_year;
                    n_state = ST_RED_E;
                end
            end
            // reduce the end year modulo 400 by repeated subtraction
            ST_RED_E: begin
                if (r_rem >= CYCLE_YRS) begin
                    n_rem = r_rem - CYCLE_YRS;
                end else begin
                    n_end_leap = leap_of(r_rem[MOD_W-1:0]);
                    n_rem      = r_in.start_year;
                    n_state    = ST_RED_S;
                end
            end
            ST_RED_S: begin
                if (r_rem >= CYCLE_YRS) begin
                    n_rem = r_rem - CYCLE_YRS;
                end else begin
                    n_mod400 = r_rem[MOD_W-1:0];
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_y     = r_in.start_year;
                n_m     = r_in.start_month;
                n_d     = r_in.start_day;
                n_count = '0;
                if (!date_ok(r_in.start_month, r_in.start_day, cur_leap) ||
                    !date_ok(r_in.end_month, r_in.end_day, r_end_leap)) begin
                    n_bad   = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_bad   = 1'b0;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!before_end || (r_count == COUNT_MAX)) begin
                    if (r_in.include_end && (r_count != COUNT_MAX)) begin
                        n_count = r_count + 22'd1;
                    end
                    n_state = ST_OUT;
                end else begin
                    n_count = r_count + 22'd1;
                    if (r_d == month_len(r_m, cur_leap)) begin
                        n_d = 5'd1;
                        if (r_m == MONTH_DEC) begin
                            n_m      = 4'd1;
                            n_y      = r_y + 14'd1;
                            n_mod400 = (r_mod400 == CYCLE_LAST) ? '0 : r_mod400 + 9'd1;
                        end else begin
                            n_m = r_m + 4'd1;
                        end
                    end else begin
                        n_d = r_d + 5'd1;
                    end
                end
            end
            // hold until the output register is free
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.day_count    = r_bad ? '0 : r_count;
                    n_out.invalid_date = r_bad;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.invalid_date |-> o_out.day_count == '0)
        else $error("invalid date beat carries a non-zero count");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STEP |-> r_mod400 <= CYCLE_LAST)
        else $error("year residue out of range while stepping");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == ST_RED_E)
        else $error("accepted beat did not start the year reduction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STEP && $past(r_state) == ST_STEP |->
        r_count == $past(r_count) + 22'd1)
        else $error("day counter did not advance by one per step");
`endif

endmodule
